// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. They expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk while rstn is high.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that cond never holds at a rising edge of clk while rstn is high.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== hdl/ghl_pkg.sv =====
// ---------------------------------------------------------------------------
// ghl_pkg
// Types and constants of the GNU hash symbol lookup block.
// ---------------------------------------------------------------------------
package ghl_pkg;

  localparam int unsigned BloomWordsDef = 64;
  localparam int unsigned BucketsDef    = 256;
  localparam int unsigned ChainDepthDef = 1024;

  localparam int unsigned IndexW    = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned BktCountW = 9;
  localparam int unsigned BloomMskW = 6;
  localparam int unsigned BloomShW  = 5;

  localparam logic [31:0] HashStart = 32'd5381;
  localparam logic [31:0] HashMul   = 32'd33;
  localparam logic        ChainEnd  = 1'b1;

  typedef enum logic [1:0] {
    KIND_BLOOM  = 2'd0,
    KIND_BUCKET = 2'd1,
    KIND_CHAIN  = 2'd2,
    KIND_KEY    = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUCKET_COUNT = 2'd0,
    CFG_SYMBOL_BIAS  = 2'd1,
    CFG_BLOOM_MASK   = 2'd2,
    CFG_BLOOM_SHIFT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    kind_e              kind;
    logic [IndexW-1:0]  index;
    logic [63:0]        table_data;
    logic [7:0]         key_byte;
    logic               key_last;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] symbol_index;
    logic [31:0] key_hash;
    logic        chain_fault;
  } rsp_t;

endpackage

// ===== hdl/ghl_if.sv =====
// ---------------------------------------------------------------------------
// ghl_req_if / ghl_rsp_if
// Valid/ready channels for requests into and results out of the lookup block.
// ---------------------------------------------------------------------------
interface ghl_req_if import ghl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ghl_rsp_if import ghl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/gnu_hash_symbol_lookup.sv =====
// ---------------------------------------------------------------------------
// gnu_hash_symbol_lookup
// GNU hash section lookup: table loading, key hashing and chain walk.
// ---------------------------------------------------------------------------
// Table writes and non-final key bytes are taken one per cycle. A request
// with the last key byte starts a lookup, and no request is taken until the
// lookup has finished. A Bloom miss ends after the Bloom word read; a Bloom
// hit goes on to the modulo, the bucket read and any chain walk. The
// length is set by the bit-serial modulo unit (one quotient bit per cycle
// for hash mod bucket_count) and by the registered read of the table
// memory, which the chain walk pays for every word. The result
// sits in an output register, so new requests are taken while it waits.
// Bloom words live in one memory; bucket heads and chain words share a
// second memory, buckets at the bottom and the chain above them. Table
// writes land only while no lookup runs, so reads never race a write.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gnu_hash_symbol_lookup import ghl_pkg::*; #(
  parameter int unsigned BLOOM_WORDS = BloomWordsDef,
  parameter int unsigned BUCKETS     = BucketsDef,
  parameter int unsigned CHAIN_DEPTH = ChainDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ghl_req_if.sink             req_i,
  ghl_rsp_if.source           rsp_o
);

  localparam int unsigned BloomAw  = (BLOOM_WORDS > 1) ? $clog2(BLOOM_WORDS) : 1;
  localparam int unsigned TabDepth = BUCKETS + CHAIN_DEPTH;
  localparam int unsigned TabAw    = $clog2(TabDepth);
  localparam int unsigned PosW     = $clog2(CHAIN_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLOOM_RD,
    S_BLOOM,
    S_MOD,
    S_BKT_RD,
    S_HEAD,
    S_CH_RD,
    S_CH,
    S_DONE
  } state_e;

  // Configuration registers.
  logic [BktCountW-1:0] bc_q;
  logic [31:0]          bias_q;
  logic [BloomMskW-1:0] bmask_q;
  logic [BloomShW-1:0]  bshift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q     <= BktCountW'(1);
      bias_q   <= '0;
      bmask_q  <= '0;
      bshift_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BUCKET_COUNT: bc_q     <= cfg_wdata_i[BktCountW-1:0];
        CFG_SYMBOL_BIAS:  bias_q   <= cfg_wdata_i;
        CFG_BLOOM_MASK:   bmask_q  <= cfg_wdata_i[BloomMskW-1:0];
        CFG_BLOOM_SHIFT:  bshift_q <= cfg_wdata_i[BloomShW-1:0];
        default: ;
      endcase
    end
  end

  state_e          state_q;
  logic [31:0]     hash_q;
  logic [31:0]     key_hash_q;
  logic            bloom_ok_q;
  logic [8:0]      rem_q;
  logic [31:0]     dvd_q;
  logic [4:0]      cnt_q;
  logic [PosW-1:0] pos_q;
  logic            res_found_q;
  logic            res_fault_q;
  logic            out_valid_q;
  rsp_t            rsp_q;

  logic req_acc;
  assign req_acc      = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.data   = rsp_q;

  // Running hash: h*33 + byte, modulo 2^32.
  logic [31:0] hash_d;
  assign hash_d = 32'(hash_q * HashMul) + 32'(req_i.data.key_byte);

  // ---------------- Bloom memory ----------------
  logic [63:0]        bloom_mem [BLOOM_WORDS];
  logic [63:0]        bloom_rdata_q;
  logic               bloom_we;
  logic               bloom_re;
  logic [BloomMskW-1:0] widx;

  assign bloom_we = req_acc && (req_i.data.kind == KIND_BLOOM)
                 && (32'(req_i.data.index) < 32'(BLOOM_WORDS));
  assign widx     = BloomMskW'(key_hash_q >> 6) & bmask_q;
  assign bloom_re = (state_q == S_BLOOM_RD);

  always_ff @(posedge clk_i) begin
    if (bloom_we) begin
      bloom_mem[BloomAw'(req_i.data.index)] <= req_i.data.table_data;
    end
    if (bloom_re) begin
      bloom_rdata_q <= bloom_mem[BloomAw'(widx)];
    end
  end

  // ---------------- Bucket and chain memory ----------------
  logic [31:0]      tab_mem [TabDepth];
  logic [31:0]      tab_rdata_q;
  logic             tab_we;
  logic [TabAw-1:0] tab_waddr;
  logic             tab_re;
  logic [TabAw-1:0] tab_raddr;

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = TabAw'(req_i.data.index);
    if (req_acc) begin
      case (req_i.data.kind)
        KIND_BUCKET: begin
          tab_we = (32'(req_i.data.index) < 32'(BUCKETS));
        end
        KIND_CHAIN: begin
          tab_we    = (32'(req_i.data.index) < 32'(CHAIN_DEPTH));
          tab_waddr = TabAw'(BUCKETS) + TabAw'(req_i.data.index);
        end
        default: ;
      endcase
    end
  end

  assign tab_re    = (state_q == S_BKT_RD) || (state_q == S_CH_RD);
  assign tab_raddr = (state_q == S_BKT_RD) ? TabAw'(rem_q)
                                           : TabAw'(BUCKETS) + TabAw'(pos_q);

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= req_i.data.table_data[31:0];
    end
    if (tab_re) begin
      tab_rdata_q <= tab_mem[tab_raddr];
    end
  end

  // ---------------- Lookup datapath ----------------
  // Bloom bits: low six hash bits and six bits after the configured shift.
  logic [5:0] b1;
  logic [5:0] b2;
  logic       bloom_hit;
  assign b1        = key_hash_q[5:0];
  assign b2        = 6'(key_hash_q >> bshift_q);
  assign bloom_hit = bloom_ok_q && bloom_rdata_q[b1] && bloom_rdata_q[b2];

  // Restoring modulo step: shift in one dividend bit, subtract if it fits.
  logic [9:0] trial;
  logic [8:0] rem_d;
  assign trial = {rem_q, dvd_q[31]};
  assign rem_d = (trial >= 10'(bc_q)) ? 9'(trial - 10'(bc_q)) : trial[8:0];

  // Chain head relative to the bias, and chain word match ignoring bit 0.
  logic [31:0] head_off;
  logic        ch_match;
  assign head_off = tab_rdata_q - bias_q;
  assign ch_match = (tab_rdata_q[31:1] == key_hash_q[31:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hash_q      <= HashStart;
      out_valid_q <= 1'b0;
      key_hash_q  <= '0;
      bloom_ok_q  <= 1'b0;
      rem_q       <= '0;
      dvd_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      res_found_q <= 1'b0;
      res_fault_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      // Drop the result once the sink takes it; a finishing lookup reloads it.
      if (out_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_acc && (req_i.data.kind == KIND_KEY)) begin
            if (req_i.data.key_last) begin
              key_hash_q <= hash_d;
              hash_q     <= HashStart;
              state_q    <= S_BLOOM_RD;
            end else begin
              hash_q <= hash_d;
            end
          end
        end
        S_BLOOM_RD: begin
          // Word index beyond the store reads as a miss.
          bloom_ok_q <= (32'(widx) < 32'(BLOOM_WORDS));
          state_q    <= S_BLOOM;
        end
        S_BLOOM: begin
          res_found_q <= 1'b0;
          res_fault_q <= 1'b0;
          rem_q       <= '0;
          dvd_q       <= key_hash_q;
          cnt_q       <= '0;
          if (bloom_hit && (bc_q != '0)) begin
            state_q <= S_MOD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_MOD: begin
          rem_q <= rem_d;
          dvd_q <= {dvd_q[30:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= S_BKT_RD;
          end
        end
        S_BKT_RD: begin
          // Bucket beyond the store reads as an empty bucket.
          if (32'(rem_q) < 32'(BUCKETS)) begin
            state_q <= S_HEAD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_HEAD: begin
          if (tab_rdata_q == '0) begin
            state_q <= S_DONE;
          end else if (tab_rdata_q < bias_q) begin
            res_fault_q <= 1'b1;
            state_q     <= S_DONE;
          end else if (head_off >= 32'(CHAIN_DEPTH)) begin
            res_fault_q <= 1'b1;
            state_q     <= S_DONE;
          end else begin
            pos_q   <= PosW'(head_off);
            state_q <= S_CH_RD;
          end
        end
        S_CH_RD: begin
          if (32'(pos_q) < 32'(CHAIN_DEPTH)) begin
            state_q <= S_CH;
          end else begin
            res_fault_q <= 1'b1;
            state_q     <= S_DONE;
          end
        end
        S_CH: begin
          if (ch_match) begin
            res_found_q <= 1'b1;
            state_q     <= S_DONE;
          end else if (tab_rdata_q[0] == ChainEnd) begin
            state_q <= S_DONE;
          end else begin
            pos_q   <= pos_q + PosW'(1);
            state_q <= S_CH_RD;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid_q || rsp_o.ready) begin
            rsp_q.found        <= res_found_q;
            rsp_q.symbol_index <= res_found_q ? (32'(pos_q) + bias_q) : '0;
            rsp_q.key_hash     <= key_hash_q;
            rsp_q.chain_fault  <= res_fault_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------- Assertions ----------------
  `ASSERT_AT(a_mod_below_divisor, clk_i, rst_ni,
    (state_q == S_BKT_RD) |-> (9'(rem_q) < bc_q), "bucket select not below bucket count")
  `ASSERT_AT(a_chain_pos_in_store, clk_i, rst_ni,
    (state_q == S_CH) |-> (32'(pos_q) < 32'(CHAIN_DEPTH)), "chain read beyond chain store")
  `ASSERT_NEVER(a_found_and_fault, clk_i, rst_ni,
    out_valid_q && rsp_q.found && rsp_q.chain_fault, "result both found and faulted")
  `ASSERT_AT(a_hash_restart, clk_i, rst_ni,
    (req_acc && (req_i.data.kind == KIND_KEY) && req_i.data.key_last) |=> (hash_q == HashStart),
    "running hash not restarted after a lookup")
  `ASSERT_NEVER(a_result_overwrite, clk_i, rst_ni,
    (state_q == S_DONE) && out_valid_q && !rsp_o.ready && !$stable(rsp_q),
    "pending result overwritten")

endmodule
